FILE: rtl/swts_pkg.sv
// Shared widths and types for the sliding window trend statistics block.
`timescale 1ns / 1ps
`default_nettype none
package swts_pkg;
   localparam int SAMPLE_W   = 16;
   localparam int PERIOD_W   = 6;
   localparam int STAT_W     = 24;
   localparam int GAIN_SUM_W = 22;
   localparam int VAL_SUM_W  = 22;
   localparam int SQ_SUM_W   = 37;
   localparam int PROD_W     = 43;
   localparam int DEV_W      = 42;
   localparam int GAIN_NUM_W = 30;
   localparam int CHG_NUM_W  = 25;
   localparam int CHG_DEN_W  = 17;
   localparam int VAR_NUM_W  = 58;
   localparam int VAR_DEN_W  = 12;
   localparam int ROOT_W     = 29;
   localparam int ABS_NUM_W  = 23;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 6'd7;
   localparam logic [6:0] PERCENT_SCALE = 7'd100;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [STAT_W-1:0] stat_type;
endpackage
`default_nettype wire

FILE: rtl/swts_if.sv
// Request and response channel interfaces.
`timescale 1ns / 1ps
`default_nettype none
interface swts_req_if import swts_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type sample;
   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface swts_rsp_if import swts_pkg::*; ();
   logic       valid;
   logic       ready;
   stat_type   mean_gain;
   logic       gain_valid;
   sample_type percent_change;
   logic       change_valid;
   logic       reference_zero;
   stat_type   std_dev;
   logic       dev_valid;
   logic       trend_switch;
   sample_type switch_sample;
   modport source (output valid, output mean_gain, output gain_valid, output percent_change,
                   output change_valid, output reference_zero, output std_dev,
                   output dev_valid, output trend_switch, output switch_sample, input ready);
   modport sink   (input valid, input mean_gain, input gain_valid, input percent_change,
                   input change_valid, input reference_zero, input std_dev,
                   input dev_valid, input trend_switch, input switch_sample, output ready);
endinterface
`default_nettype wire

FILE: rtl/swts_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module swts_div #(
   parameter int NUM_W = 30,
   parameter int DEN_W = 6
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic                  done,
   output logic [NUM_W-1:0]      quot
);
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff, done_ff;
   logic [DEN_W:0]   trial, diff;
   logic             ge;

   always_comb begin
      trial  = {rem_ff, num_ff[NUM_W-1]};
      ge     = trial >= {1'b0, den_ff};
      diff   = trial - {1'b0, den_ff};
      rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      num_in = {num_ff[NUM_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(NUM_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= num;
         den_ff <= den;
         rem_ff <= '0;
      end else if (busy_ff) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
      end
   end

   assign done = done_ff;
   assign quot = num_ff;
endmodule
`default_nettype wire

FILE: rtl/swts_sqrt.sv
// Digit-serial integer square root, one root bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module swts_sqrt #(
   parameter int RW = 29
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   input  wire logic [2*RW-1:0] radicand,
   output logic                 done,
   output logic [RW-1:0]        root
);
   localparam int CNT_W = $clog2(RW + 1);

   logic [2*RW-1:0] val_ff;
   logic [RW-1:0]   root_ff;
   logic [RW:0]     rem_ff, rem_in;
   logic [RW+2:0]   trial_rem, trial, diff;
   logic            ge;
   logic [CNT_W-1:0] cnt_ff;
   logic            busy_ff, done_ff;

   always_comb begin
      trial_rem = {rem_ff, val_ff[2*RW-1:2*RW-2]};
      trial     = {1'b0, root_ff, 2'b01};
      ge        = trial_rem >= trial;
      diff      = trial_rem - trial;
      rem_in    = ge ? diff[RW:0] : trial_rem[RW:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(RW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         val_ff  <= radicand;
         root_ff <= '0;
         rem_ff  <= '0;
      end else if (busy_ff) begin
         val_ff  <= {val_ff[2*RW-3:0], 2'b00};
         root_ff <= {root_ff[RW-2:0], ge};
         rem_ff  <= rem_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule
`default_nettype wire

FILE: rtl/sliding_window_trend_stats_core.sv
// Top level of the sliding window trend statistics block.
//
//  channel  | direction | handshake      | payload
//  req_ch   | in        | valid/ready    | sample
//  rsp_ch   | out       | valid/ready    | mean_gain .. switch_sample
//  csr_*    | in        | write enable   | window_period
//
// Each request makes P + 1 ring reads through the single read port (P = clamped
// window period), forms the wide products in S_MUL and S_START, then runs the
// 58-step variance divider and the 29-step square root in series before the
// response is registered in S_OUT; the gain and change dividers run alongside. The
// next request is accepted only after the previous one has returned to S_IDLE.
// Reset is synchronous and clears control, sums, head, count and previous change;
// the ring itself is never cleared. A held response does not block the next
// request; only a finished result waiting behind a held one stalls the engine.
`timescale 1ns / 1ps
`default_nettype none
module sliding_window_trend_stats_core
   import swts_pkg::*;
#(
   parameter int RING_DEPTH = 64
) (
   input  wire logic                clock,
   input  wire logic                reset,
   swts_req_if.sink                 req_ch,
   swts_rsp_if.source               rsp_ch,
   input  wire logic                csr_we,
   input  wire logic [PERIOD_W-1:0] csr_wdata
);
   localparam int ADDR_W = $clog2(RING_DEPTH);
   localparam int CNT_W  = $clog2(RING_DEPTH + 1);
   localparam int CMP_W  = (CNT_W > PERIOD_W) ? CNT_W : PERIOD_W;
   localparam logic [PERIOD_W-1:0] PMAX =
      PERIOD_W'((RING_DEPTH - 1 > 63) ? 63 : RING_DEPTH - 1);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(RING_DEPTH - 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_LOOP  = 3'd1;
   localparam logic [2:0] S_MUL   = 3'd2;
   localparam logic [2:0] S_START = 3'd3;
   localparam logic [2:0] S_DIV   = 3'd4;
   localparam logic [2:0] S_SQRT  = 3'd5;
   localparam logic [2:0] S_OUT   = 3'd6;

   // ring memory
   sample_type ring [RING_DEPTH];
   sample_type rd_data_ff;

   logic [2:0]          state_ff;
   logic [PERIOD_W-1:0] cfg_ff, p_ff, p_clamp;
   logic [ADDR_W-1:0]   head_ff, rd_addr_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [PERIOD_W-1:0] iss_k_ff, t1_k_ff;
   logic                issue_ff, t1_v_ff, t2_v_ff;
   logic                req_take;

   sample_type                  prev_ff, newest_ff, ref_ff;
   logic [GAIN_SUM_W-1:0]       gain_sum_ff;
   logic signed [VAL_SUM_W-1:0] value_sum_ff;
   logic [SQ_SUM_W-1:0]         square_sum_ff;
   logic [31:0]                 sq_ff;
   logic signed [SAMPLE_W:0]    step, chg_diff_ff;
   logic [PROD_W-1:0]           pq_ff, ss_ff;
   logic [ABS_NUM_W-1:0]        an_ff;
   logic [VAR_DEN_W-1:0]        pp_ff;
   logic [SAMPLE_W-1:0]         ad;
   logic [SAMPLE_W-1:0]         abs_diff;
   logic [DEV_W-1:0]            dev;
   logic                        gain_ok, dev_ok;
   sample_type                  prev_change_ff, change;

   logic                  div_start, var_done, sqrt_done;
   logic                  started_ff;
   logic [GAIN_NUM_W-1:0] gain_q;
   logic [CHG_NUM_W-1:0]  chg_q;
   logic [VAR_NUM_W-1:0]  var_q;
   logic [ROOT_W-1:0]     root;

   logic                  rsp_v_ff;
   stat_type              mean_ff, std_ff;
   logic                  gv_ff, cv_ff, rz_ff, dv_ff, ts_ff;
   sample_type            pct_ff, sw_ff;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_take     = req_ch.valid && req_ch.ready;

   always_comb begin
      p_clamp = (cfg_ff == '0) ? PERIOD_W'(1) : cfg_ff;
      if (p_clamp > PMAX) p_clamp = PMAX;
   end

   assign gain_ok = CMP_W'(count_ff) > CMP_W'(p_ff);
   assign dev_ok  = CMP_W'(count_ff) >= CMP_W'(p_ff);

   // write on accept, read one entry a cycle during the sweep
   always_ff @(posedge clock) begin
      if (req_take) ring[head_ff] <= req_ch.sample;
      rd_data_ff <= ring[rd_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= PERIOD_RESET;
      end else if (csr_we) begin
         cfg_ff <= csr_wdata;
      end
   end

   assign step = $signed({prev_ff[SAMPLE_W-1], prev_ff}) -
                 $signed({rd_data_ff[SAMPLE_W-1], rd_data_ff});

   // sweep control and accumulation
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         head_ff       <= '0;
         count_ff      <= '0;
         issue_ff      <= 1'b0;
         t1_v_ff       <= 1'b0;
         t2_v_ff       <= 1'b0;
         gain_sum_ff   <= '0;
         value_sum_ff  <= '0;
         square_sum_ff <= '0;
         prev_change_ff <= '0;
         rsp_v_ff      <= 1'b0;
      end else begin
         if (rsp_ch.ready) rsp_v_ff <= 1'b0;
         t1_v_ff <= issue_ff;
         t2_v_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_take) begin
                  rd_addr_ff    <= head_ff;
                  head_ff       <= (head_ff == LAST_ADDR) ? '0 : head_ff + 1'b1;
                  if (count_ff != CNT_W'(RING_DEPTH)) count_ff <= count_ff + 1'b1;
                  p_ff          <= p_clamp;
                  iss_k_ff      <= '0;
                  issue_ff      <= 1'b1;
                  gain_sum_ff   <= '0;
                  value_sum_ff  <= '0;
                  square_sum_ff <= '0;
                  state_ff      <= S_LOOP;
               end
            end
            S_LOOP: begin
               if (issue_ff) begin
                  // walk backwards from the newest entry
                  rd_addr_ff <= (rd_addr_ff == '0) ? LAST_ADDR : rd_addr_ff - 1'b1;
                  iss_k_ff   <= iss_k_ff + 1'b1;
                  if (iss_k_ff == p_ff) issue_ff <= 1'b0;
               end
               if (t1_v_ff) begin
                  prev_ff <= rd_data_ff;
                  if (t1_k_ff == '0) newest_ff <= rd_data_ff;
                  if (t1_k_ff == p_ff) begin
                     ref_ff   <= rd_data_ff;
                     state_ff <= S_MUL;
                  end
                  if (t1_k_ff != '0 && !step[SAMPLE_W] && step != '0)
                     gain_sum_ff <= gain_sum_ff + GAIN_SUM_W'(step[SAMPLE_W-1:0]);
                  if (t1_k_ff < p_ff) begin
                     value_sum_ff <= value_sum_ff + VAL_SUM_W'(rd_data_ff);
                     sq_ff        <= 32'(rd_data_ff) * 32'(rd_data_ff);
                     t2_v_ff      <= 1'b1;
                  end
               end
               if (t2_v_ff) square_sum_ff <= square_sum_ff + SQ_SUM_W'(sq_ff);
            end
            S_MUL:   state_ff <= S_START;
            S_START: state_ff <= S_DIV;
            S_DIV:   if (var_done) state_ff <= S_SQRT;
            S_SQRT:  if (sqrt_done) state_ff <= S_OUT;
            S_OUT: begin
               // hold until the response register is free
               if (!rsp_v_ff || rsp_ch.ready) begin
                  rsp_v_ff <= 1'b1;
                  if (gain_ok) prev_change_ff <= change;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      t1_k_ff <= iss_k_ff;
   end

   assign abs_diff = chg_diff_ff[SAMPLE_W] ? SAMPLE_W'(-chg_diff_ff) : chg_diff_ff[SAMPLE_W-1:0];
   assign ad       = ref_ff[SAMPLE_W-1] ? SAMPLE_W'(-ref_ff) : ref_ff;

   // wide products, each registered before use
   always_ff @(posedge clock) begin
      if (state_ff == S_MUL) begin
         pq_ff       <= PROD_W'(p_ff) * PROD_W'(square_sum_ff);
         ss_ff       <= PROD_W'(value_sum_ff) * PROD_W'(value_sum_ff);
         pp_ff       <= VAR_DEN_W'(p_ff) * VAR_DEN_W'(p_ff);
         chg_diff_ff <= $signed({newest_ff[SAMPLE_W-1], newest_ff}) -
                        $signed({ref_ff[SAMPLE_W-1], ref_ff});
      end
      if (state_ff == S_START)
         an_ff <= ABS_NUM_W'(abs_diff) * ABS_NUM_W'(PERCENT_SCALE);
   end

   assign dev = DEV_W'(pq_ff - ss_ff);

   // start all dividers in the first S_DIV cycle, once every product is registered
   assign div_start = (state_ff == S_DIV) && !started_ff;
   always_ff @(posedge clock) begin
      if (reset) started_ff <= 1'b0;
      else started_ff <= (state_ff == S_DIV);
   end

   swts_div #(.NUM_W(GAIN_NUM_W), .DEN_W(PERIOD_W)) u_gain_div (
      .clock(clock), .reset(reset), .start(div_start),
      .num({gain_sum_ff, 8'd0} + GAIN_NUM_W'(p_ff >> 1)),
      .den(p_ff), .done(), .quot(gain_q));

   swts_div #(.NUM_W(CHG_NUM_W), .DEN_W(CHG_DEN_W)) u_chg_div (
      .clock(clock), .reset(reset), .start(div_start),
      .num({1'b0, an_ff, 1'b0} + CHG_NUM_W'(ad)),
      .den({ad, 1'b0}), .done(), .quot(chg_q));

   swts_div #(.NUM_W(VAR_NUM_W), .DEN_W(VAR_DEN_W)) u_var_div (
      .clock(clock), .reset(reset), .start(div_start),
      .num({dev, 16'd0}), .den(pp_ff), .done(var_done), .quot(var_q));

   swts_sqrt #(.RW(ROOT_W)) u_sqrt (
      .clock(clock), .reset(reset), .start(var_done),
      .radicand(var_q), .done(sqrt_done), .root(root));

   // sign and saturation of the percent change
   always_comb begin
      if (ref_ff == '0) begin
         change = '0;
      end else if (chg_diff_ff[SAMPLE_W] ^ ref_ff[SAMPLE_W-1]) begin
         change = (chg_q > CHG_NUM_W'(32768)) ? sample_type'(16'h8000)
                                              : sample_type'(SAMPLE_W'(-chg_q));
      end else begin
         change = (chg_q > CHG_NUM_W'(32767)) ? sample_type'(16'h7fff)
                                              : sample_type'(chg_q[SAMPLE_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_OUT && (!rsp_v_ff || rsp_ch.ready)) begin
         gv_ff   <= gain_ok;
         mean_ff <= gain_ok ? gain_q[STAT_W-1:0] : '0;
         pct_ff  <= gain_ok ? change : '0;
         cv_ff   <= gain_ok && (ref_ff != '0);
         rz_ff   <= gain_ok && (ref_ff == '0);
         ts_ff   <= gain_ok && ((prev_change_ff > 0 && change < 0) ||
                                (prev_change_ff < 0 && change > 0));
         sw_ff   <= (gain_ok && ((prev_change_ff > 0 && change < 0) ||
                                 (prev_change_ff < 0 && change > 0))) ? ref_ff : '0;
         dv_ff   <= dev_ok;
         std_ff  <= dev_ok ? root[STAT_W-1:0] : '0;
      end
   end

   assign rsp_ch.valid          = rsp_v_ff;
   assign rsp_ch.mean_gain      = mean_ff;
   assign rsp_ch.gain_valid     = gv_ff;
   assign rsp_ch.percent_change = pct_ff;
   assign rsp_ch.change_valid   = cv_ff;
   assign rsp_ch.reference_zero = rz_ff;
   assign rsp_ch.std_dev        = std_ff;
   assign rsp_ch.dev_valid      = dv_ff;
   assign rsp_ch.trend_switch   = ts_ff;
   assign rsp_ch.switch_sample  = sw_ff;
endmodule
`default_nettype wire
